### rtl/esgdq_pkg.sv
// Shared types, codes and constants for the eye sample gap dilation quality core.
// Used by the datapath, controller, top level and bench; depends on nothing.
package esgdq_pkg;

    localparam int COUNT_BITS_DEF  = 20;
    localparam int HEIGHT_BITS_DEF = 16;

    // Field widths of the stream items
    localparam int PUPIL_W = 16;
    localparam int CNT_W   = 20;
    localparam int PCT_W   = 14;
    localparam int MEAN_W  = 27;
    localparam int KIND_W  = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 168;

    // Scale factors of the rounded quotients
    localparam int PCT_SCALE  = 20000;
    localparam int MEAN_SCALE = 200;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LEFT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RIGHT  = 2'd2;

    // Summary quotient selectors (low bits of the division index)
    localparam logic [1:0] DIV_PCT_BEFORE  = 2'd0;
    localparam logic [1:0] DIV_PCT_AFTER   = 2'd1;
    localparam logic [1:0] DIV_MEAN_BEFORE = 2'd2;
    localparam logic [1:0] DIV_MEAN_AFTER  = 2'd3;

    // Configuration register index
    localparam logic REG_PUPIL_MODE = 1'b0;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_OLD,
        EMIT_H1,
        EMIT_H0
    } emit_sel_t;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_EMIT0     = 7'b0000010,
        ST_EMIT1     = 7'b0000100,
        ST_EMIT2     = 7'b0001000,
        ST_DIV_START = 7'b0010000,
        ST_DIV_WAIT  = 7'b0100000,
        ST_SUM_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic      accept;
        emit_sel_t emit;
        logic      div_start;
        logic      div_store;
        logic [2:0] div_idx;
        logic      sum_load;
        logic      clear;
    } cmd_t;

    typedef struct packed {
        logic emit0_valid;
        logic hist_full;
        logic trial_end;
        logic out_free;
        logic div_done;
    } status_t;

endpackage

### rtl/esgdq_div.sv
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// Depends on nothing.
module esgdq_div #(
    parameter int NW = 36,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic          zero_reg, zero_next;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    // Shift one numerator bit in per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NW);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NW-2:0], 1'b0};
            if (fits)
            begin
                rem_next = DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
            quo_next = {quo_reg[NW-2:0], fits & ~zero_reg};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/esgdq_eye.sv
// Per-eye history, gap widening and trial counters.
// Depends on nothing; instantiated once for each eye by the datapath.
module esgdq_eye #(
    parameter int CB = 20,
    parameter int HB = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mode,
    input  logic          accept,
    input  logic          ok,
    input  logic [HB-1:0] height,
    input  logic [1:0]    fill,
    input  logic          final_en,
    input  logic          final_ok,
    input  logic          clear,
    output logic          hok0,
    output logic          hok1,
    output logic          emit_old,
    output logic [CB-1:0] vb,
    output logic [CB-1:0] va,
    output logic [CB-1:0] ob,
    output logic [CB-1:0] nb
);
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    logic          hok0_reg, hok1_reg, emit_old_reg;
    logic [HB-1:0] h0_reg, h1_reg;
    logic [1:0]    pend_reg;
    logic [CB-1:0] vb_reg, va_reg, orun_reg, osec_reg, nrun_reg, nsec_reg;
    logic          fall, widen, cur;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
        return (v != CMAX) ? v + 1'b1 : v;
    endfunction

    // Widen on an invalid sample; in pupil mode with full history, only on zero or falling height
    assign fall  = (height == '0) || ((h1_reg > h0_reg) && (h0_reg > height));
    assign widen = !ok && (!(mode && fill == 2'd2) || fall);
    assign cur   = ok && (pend_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hok0_reg     <= 1'b0;
            hok1_reg     <= 1'b0;
            emit_old_reg <= 1'b0;
            h0_reg       <= '0;
            h1_reg       <= '0;
            pend_reg     <= '0;
            vb_reg       <= '0;
            va_reg       <= '0;
            orun_reg     <= '0;
            osec_reg     <= '0;
            nrun_reg     <= '0;
            nsec_reg     <= '0;
        end
        else if (clear)
        begin
            hok0_reg     <= 1'b0;
            hok1_reg     <= 1'b0;
            emit_old_reg <= 1'b0;
            h0_reg       <= '0;
            h1_reg       <= '0;
            pend_reg     <= '0;
            vb_reg       <= '0;
            va_reg       <= '0;
            orun_reg     <= '0;
            osec_reg     <= '0;
            nrun_reg     <= '0;
            nsec_reg     <= '0;
        end
        else
        begin
            // Take a new sample: count, widen, shift history
            if (accept)
            begin
                if (ok)
                begin
                    vb_reg <= sat_inc(vb_reg);
                end
                else
                begin
                    orun_reg <= sat_inc(orun_reg);
                end
                if (widen)
                begin
                    pend_reg <= 2'd2;
                end
                else if (ok && pend_reg != 2'd0)
                begin
                    pend_reg <= pend_reg - 1'b1;
                end
                if (cur)
                begin
                    osec_reg <= sat_inc(osec_reg);
                    orun_reg <= '0;
                end
                emit_old_reg <= widen ? 1'b0 : hok1_reg;
                hok1_reg     <= widen ? 1'b0 : hok0_reg;
                hok0_reg     <= cur;
                h1_reg       <= h0_reg;
                h0_reg       <= height;
            end
            // Count a corrected sample as it leaves
            if (final_en)
            begin
                if (final_ok)
                begin
                    va_reg   <= sat_inc(va_reg);
                    nsec_reg <= sat_inc(nsec_reg);
                    nrun_reg <= '0;
                end
                else
                begin
                    nrun_reg <= sat_inc(nrun_reg);
                end
            end
        end
    end

    assign hok0     = hok0_reg;
    assign hok1     = hok1_reg;
    assign emit_old = emit_old_reg;
    assign vb       = vb_reg;
    assign va       = va_reg;
    assign ob       = (orun_reg != '0) ? sat_inc(osec_reg) : osec_reg;
    assign nb       = (nrun_reg != '0) ? sat_inc(nsec_reg) : nsec_reg;

endmodule

### rtl/esgdq_dp.sv
// Datapath: both eyes, sample counter, summary divider and output register.
// Depends on esgdq_pkg, esgdq_eye and esgdq_div.
module esgdq_dp
    import esgdq_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mode,
    input  cmd_t                  cmd,
    output status_t               st,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);
    localparam int CB = COUNT_BITS;
    localparam int HB = HEIGHT_BITS;
    localparam int NW = CB + 16;
    localparam int DW = CB + 1;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    logic [1:0]    fill_reg;
    logic [CB-1:0] total_reg;
    logic          end_reg, emit0_valid_reg;
    logic [HB-1:0] lh, rh;
    logic [31:0]   lh_wide, rh_wide;

    logic          l_hok0, l_hok1, l_old, r_hok0, r_hok1, r_old;
    logic [CB-1:0] l_vb, l_va, l_ob, l_nb, r_vb, r_va, r_ob, r_nb;
    logic          final_en, fl_ok, fr_ok;

    logic [CB-1:0] e_vb, e_va, e_ob, e_nb, e_eb, e_ea;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;
    logic          div_done;
    logic [63:0]   quo_wide;

    logic [PCT_W-1:0]  qb_reg, qa_reg;
    logic [MEAN_W-1:0] mb_reg, ma_reg;

    logic                  out_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic                  lok_reg, rok_reg, last_reg;
    logic [CNT_W-1:0]      tot_o_reg, vb_o_reg, va_o_reg, err_o_reg;
    logic [PCT_W-1:0]      qb_o_reg, qa_o_reg;
    logic [MEAN_W-1:0]     mb_o_reg, ma_o_reg;
    logic                  out_free, load;

    function automatic logic [CNT_W-1:0] to_cnt(input logic [CB-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[CNT_W-1:0];
    endfunction

    // Pupil heights at the internal width
    assign lh_wide = 32'(s_tdata[16:1]);
    assign rh_wide = 32'(s_tdata[33:18]);
    assign lh      = lh_wide[HB-1:0];
    assign rh      = rh_wide[HB-1:0];

    // Corrected flags of the sample leaving now
    always_comb
    begin
        final_en = 1'b1;
        fl_ok    = 1'b0;
        fr_ok    = 1'b0;
        case (cmd.emit)
            EMIT_OLD:
            begin
                fl_ok = l_old;
                fr_ok = r_old;
            end
            EMIT_H1:
            begin
                fl_ok = l_hok1;
                fr_ok = r_hok1;
            end
            EMIT_H0:
            begin
                fl_ok = l_hok0;
                fr_ok = r_hok0;
            end
            default:
            begin
                final_en = 1'b0;
            end
        endcase
    end

    esgdq_eye #(.CB(CB), .HB(HB)) u_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .accept   (cmd.accept),
        .ok       (s_tdata[0]),
        .height   (lh),
        .fill     (fill_reg),
        .final_en (final_en),
        .final_ok (fl_ok),
        .clear    (cmd.clear),
        .hok0     (l_hok0),
        .hok1     (l_hok1),
        .emit_old (l_old),
        .vb       (l_vb),
        .va       (l_va),
        .ob       (l_ob),
        .nb       (l_nb)
    );

    esgdq_eye #(.CB(CB), .HB(HB)) u_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .accept   (cmd.accept),
        .ok       (s_tdata[17]),
        .height   (rh),
        .fill     (fill_reg),
        .final_en (final_en),
        .final_ok (fr_ok),
        .clear    (cmd.clear),
        .hok0     (r_hok0),
        .hok1     (r_hok1),
        .emit_old (r_old),
        .vb       (r_vb),
        .va       (r_va),
        .ob       (r_ob),
        .nb       (r_nb)
    );

    // Trial-level control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            total_reg       <= '0;
            end_reg         <= 1'b0;
            emit0_valid_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            fill_reg        <= '0;
            total_reg       <= '0;
            end_reg         <= 1'b0;
            emit0_valid_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (fill_reg != 2'd2)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (total_reg != CMAX)
            begin
                total_reg <= total_reg + 1'b1;
            end
            end_reg         <= s_tlast;
            emit0_valid_reg <= (fill_reg == 2'd2);
        end
    end

    // Select the eye and operands of the current summary division
    assign e_vb = cmd.div_idx[2] ? r_vb : l_vb;
    assign e_va = cmd.div_idx[2] ? r_va : l_va;
    assign e_ob = cmd.div_idx[2] ? r_ob : l_ob;
    assign e_nb = cmd.div_idx[2] ? r_nb : l_nb;
    assign e_eb = (total_reg >= e_vb) ? total_reg - e_vb : '0;
    assign e_ea = (total_reg >= e_va) ? total_reg - e_va : '0;

    always_comb
    begin
        case (cmd.div_idx[1:0])
            DIV_PCT_BEFORE:
            begin
                div_num = NW'(e_vb) * NW'(PCT_SCALE) + NW'(total_reg);
                div_den = {total_reg, 1'b0};
            end
            DIV_PCT_AFTER:
            begin
                div_num = NW'(e_va) * NW'(PCT_SCALE) + NW'(total_reg);
                div_den = {total_reg, 1'b0};
            end
            DIV_MEAN_BEFORE:
            begin
                div_num = NW'(e_eb) * NW'(MEAN_SCALE) + NW'(e_ob);
                div_den = {e_ob, 1'b0};
            end
            default:
            begin
                div_num = NW'(e_ea) * NW'(MEAN_SCALE) + NW'(e_nb);
                div_den = {e_nb, 1'b0};
            end
        endcase
    end

    esgdq_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign quo_wide = 64'(div_quo);

    // Hold the four quotients of one summary
    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.div_idx[1:0])
                DIV_PCT_BEFORE:  qb_reg <= quo_wide[PCT_W-1:0];
                DIV_PCT_AFTER:   qa_reg <= quo_wide[PCT_W-1:0];
                DIV_MEAN_BEFORE: mb_reg <= quo_wide[MEAN_W-1:0];
                default:         ma_reg <= quo_wide[MEAN_W-1:0];
            endcase
        end
    end

    // Output register
    assign out_free = !out_valid_reg || m_tready;
    assign load     = final_en || cmd.sum_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (final_en)
        begin
            kind_reg  <= KIND_SAMPLE;
            lok_reg   <= fl_ok;
            rok_reg   <= fr_ok;
            tot_o_reg <= '0;
            vb_o_reg  <= '0;
            va_o_reg  <= '0;
            err_o_reg <= '0;
            qb_o_reg  <= '0;
            qa_o_reg  <= '0;
            mb_o_reg  <= '0;
            ma_o_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else if (cmd.sum_load)
        begin
            kind_reg  <= cmd.div_idx[2] ? KIND_RIGHT : KIND_LEFT;
            lok_reg   <= 1'b0;
            rok_reg   <= 1'b0;
            tot_o_reg <= to_cnt(total_reg);
            vb_o_reg  <= to_cnt(e_vb);
            va_o_reg  <= to_cnt(e_va);
            err_o_reg <= to_cnt(e_eb);
            qb_o_reg  <= qb_reg;
            qa_o_reg  <= qa_reg;
            mb_o_reg  <= mb_reg;
            ma_o_reg  <= ma_reg;
            last_reg  <= cmd.div_idx[2];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'd0, ma_o_reg, mb_o_reg, qa_o_reg, qb_o_reg, err_o_reg,
                       va_o_reg, vb_o_reg, tot_o_reg, rok_reg, lok_reg};

    assign st.emit0_valid = emit0_valid_reg;
    assign st.hist_full   = (fill_reg == 2'd2);
    assign st.trial_end   = end_reg;
    assign st.out_free    = out_free;
    assign st.div_done    = div_done;

endmodule

### rtl/esgdq_ctrl.sv
// Controller: sequences sample intake, corrected sample output and trial summaries.
// Depends on esgdq_pkg.
module esgdq_ctrl
    import esgdq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);
    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.emit      = EMIT_NONE;
        cmd.div_idx   = idx_reg;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EMIT0;
                end
            end
            // Emit the sample that just became final
            ST_EMIT0:
            begin
                if (!st.emit0_valid)
                begin
                    state_next = st.trial_end ? ST_EMIT1 : ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = EMIT_OLD;
                    state_next = st.trial_end ? ST_EMIT1 : ST_IDLE;
                end
            end
            // Flush the held samples at trial end
            ST_EMIT1:
            begin
                if (!st.hist_full)
                begin
                    state_next = ST_EMIT2;
                end
                else if (st.out_free)
                begin
                    cmd.emit   = EMIT_H1;
                    state_next = ST_EMIT2;
                end
            end
            ST_EMIT2:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = EMIT_H0;
                    idx_next   = 3'd0;
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (st.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (idx_reg[1:0] == DIV_MEAN_AFTER)
                    begin
                        state_next = ST_SUM_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            // Left summary, then right summary and trial clear
            ST_SUM_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.sum_load = 1'b1;
                    if (!idx_reg[2])
                    begin
                        idx_next   = 3'd4;
                        state_next = ST_DIV_START;
                    end
                    else
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTH
    a_accept_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == ST_EMIT0)
        else $error("accepted item not followed by emit state");
    a_div_waits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == ST_DIV_WAIT && !cmd.div_start)
        else $error("division start not followed by wait");
    a_clear_right: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> cmd.sum_load && idx_reg[2])
        else $error("trial clear outside right summary");
    a_store_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_store |-> st.div_done && state_reg == ST_DIV_WAIT)
        else $error("quotient stored without finished division");
`endif

endmodule

### rtl/eye_sample_gap_dilation_quality_core.sv
// Eye sample gap dilation quality core: widens per-eye gaps, emits corrected samples and
// per-trial summaries with divided quality figures. Top level; depends on esgdq_pkg,
// esgdq_ctrl and esgdq_dp.
//
// Each sample is accepted in ST_IDLE; ST_EMIT0 then emits, once the output is free, the
// corrected sample that became final two samples back. A sample marked trial end also
// flushes the two held samples and then runs eight divisions for the two summaries on one
// shared bit-serial divider. No new sample is taken until the right summary has been
// loaded and the trial cleared.
// The pupil_mode register sits at byte address 0 and applies from the next sample on.
module eye_sample_gap_dilation_quality_core
    import esgdq_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // left_ok, left_pupil[15:0], right_ok, right_pupil[15:0], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tlast,
    // left_ok_fixed, right_ok_fixed, sample_total, valid_before, valid_after,
    // error_samples, quality_before, quality_after, mean_gap_before, mean_gap_after, pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    cmd_t    cmd;
    status_t st;
    logic    mode_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_PUPIL_MODE)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PUPIL_MODE) ? {31'd0, mode_reg} : 32'd0;

    esgdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    esgdq_dp #(
        .COUNT_BITS  (COUNT_BITS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for eye_sample_gap_dilation_quality_core: random and directed samples,
// a gap-widening predictor with per-eye summary arithmetic, and a scoreboard of results.
// Depends on esgdq_pkg and the core.
module tb_top;
    import esgdq_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic        lfix;
        logic        rfix;
        logic [19:0] total;
        logic [19:0] vb;
        logic [19:0] va;
        logic [19:0] errs;
        logic [13:0] qb;
        logic [13:0] qa;
        logic [26:0] mb;
        logic [26:0] ma;
        logic        last;
    } result_t;

    localparam logic [19:0] CMAX = 20'hFFFFF;

    // Per-eye predictor state
    typedef struct {
        logic        hok [2];
        logic [15:0] hh [2];
        logic [1:0]  pend;
        logic [19:0] vb, va, orun, osec, nrun, nsec;
    } eye_state_t;

    int errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    class result_board;
        result_t pending_q[$];
        int      checked;

        function void note(input result_t r);
            pending_q = {pending_q, r};
        endfunction

        task check(input result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (got.kind != want.kind) report($sformatf("kind %0d/%0d", got.kind, want.kind));
            if (got.lfix != want.lfix) report($sformatf("lfix %0d/%0d", got.lfix, want.lfix));
            if (got.rfix != want.rfix) report($sformatf("rfix %0d/%0d", got.rfix, want.rfix));
            if (got.total != want.total) report($sformatf("total %0d/%0d", got.total, want.total));
            if (got.vb != want.vb) report($sformatf("vb %0d/%0d", got.vb, want.vb));
            if (got.va != want.va) report($sformatf("va %0d/%0d", got.va, want.va));
            if (got.errs != want.errs) report($sformatf("errs %0d/%0d", got.errs, want.errs));
            if (got.qb != want.qb) report($sformatf("qb %0d/%0d", got.qb, want.qb));
            if (got.qa != want.qa) report($sformatf("qa %0d/%0d", got.qa, want.qa));
            if (got.mb != want.mb) report($sformatf("mb %0d/%0d", got.mb, want.mb));
            if (got.ma != want.ma) report($sformatf("ma %0d/%0d", got.ma, want.ma));
            if (got.last != want.last) report($sformatf("last %0d/%0d", got.last, want.last));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic                  s_tlast = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic                  m_tlast;
    logic                  psel = 0, penable = 0, pwrite = 0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    always #2 clk = ~clk;

    eye_sample_gap_dilation_quality_core i_dut (.*);

    result_board board = new();
    logic        mode;
    eye_state_t  le, re;
    logic [1:0]  fill;
    logic [19:0] count;
    bit          calm;
    int          n_trials, n_samples;

    function automatic logic [19:0] inc(input logic [19:0] v);
        return v < CMAX ? v + 20'd1 : v;
    endfunction

    function automatic logic [13:0] percent(input logic [19:0] v, input logic [19:0] t);
        longint unsigned num;
        if (t == 0) return '0;
        num = 64'd20000 * v + t;
        return 14'(num / (64'd2 * t));
    endfunction

    function automatic logic [26:0] gap_mean(input logic [19:0] s, input logic [19:0] n);
        longint unsigned num;
        if (n == 0) return '0;
        num = 64'd200 * s + n;
        return 27'(num / (64'd2 * n));
    endfunction

    function automatic void clear_eye(ref eye_state_t e);
        e.hok[0] = 0; e.hok[1] = 0; e.hh[0] = 0; e.hh[1] = 0; e.pend = 0;
        e.vb = 0; e.va = 0; e.orun = 0; e.osec = 0; e.nrun = 0; e.nsec = 0;
    endfunction

    // Widen one eye for an incoming sample; returns its tentative flag
    function automatic logic widen_eye(ref eye_state_t e, input logic ok, input logic [15:0] h);
        if (ok)
        begin
            e.vb = inc(e.vb);
            if (e.pend > 0)
            begin
                e.pend--;
                return 0;
            end
            e.osec = inc(e.osec);
            e.orun = 0;
            return 1;
        end
        e.orun = inc(e.orun);
        if (mode && fill >= 2)
        begin
            if (h == 0 || (e.hh[1] > e.hh[0] && e.hh[0] > h))
            begin
                e.hok[0] = 0; e.hok[1] = 0; e.pend = 2;
            end
        end
        else
        begin
            if (fill >= 1) e.hok[0] = 0;
            if (fill >= 2) e.hok[1] = 0;
            e.pend = 2;
        end
        return 0;
    endfunction

    function automatic void settle_eye(ref eye_state_t e, input logic ok);
        if (ok)
        begin
            e.va = inc(e.va); e.nsec = inc(e.nsec); e.nrun = 0;
        end
        else e.nrun = inc(e.nrun);
    endfunction

    function automatic void expect_sample(input logic l, input logic r);
        result_t x = '0;
        x.kind = KIND_SAMPLE; x.lfix = l; x.rfix = r;
        settle_eye(le, l);
        settle_eye(re, r);
        board.note(x);
    endfunction

    function automatic void expect_summary(input logic [1:0] k, input eye_state_t e);
        result_t x = '0;
        logic [19:0] ob, nb, eb, ea;
        eb = count >= e.vb ? count - e.vb : '0;
        ea = count >= e.va ? count - e.va : '0;
        ob = e.orun != 0 ? inc(e.osec) : e.osec;
        nb = e.nrun != 0 ? inc(e.nsec) : e.nsec;
        x.kind = k; x.total = count; x.vb = e.vb; x.va = e.va; x.errs = eb;
        x.qb = percent(e.vb, count); x.qa = percent(e.va, count);
        x.mb = gap_mean(eb, ob); x.ma = gap_mean(ea, nb);
        x.last = (k == KIND_RIGHT);
        board.note(x);
    endfunction

    // Predict all results caused by one accepted sample
    function automatic void predict_sample(input logic lok, input logic [15:0] lh,
                                           input logic rok, input logic [15:0] rh,
                                           input logic tend);
        logic lc, rc;
        count = inc(count);
        lc = widen_eye(le, lok, lh);
        rc = widen_eye(re, rok, rh);
        if (fill >= 2) expect_sample(le.hok[1], re.hok[1]);
        le.hok[1] = le.hok[0]; le.hh[1] = le.hh[0]; le.hok[0] = lc; le.hh[0] = lh;
        re.hok[1] = re.hok[0]; re.hh[1] = re.hh[0]; re.hok[0] = rc; re.hh[0] = rh;
        if (fill < 2) fill++;
        if (tend)
        begin
            if (fill >= 2) expect_sample(le.hok[1], re.hok[1]);
            expect_sample(le.hok[0], re.hok[0]);
            expect_summary(KIND_LEFT, le);
            expect_summary(KIND_RIGHT, re);
            clear_eye(le); clear_eye(re); fill = 0; count = 0;
            n_trials++;
        end
    endfunction

    function automatic bit idle_now();
        return !calm && $urandom_range(99) < 7;
    endfunction

    // Unpack the result item on the output ports
    function automatic result_t take_result();
        result_t r;
        r.kind  = m_tuser;
        r.lfix  = m_tdata[0];
        r.rfix  = m_tdata[1];
        r.total = m_tdata[21:2];
        r.vb    = m_tdata[41:22];
        r.va    = m_tdata[61:42];
        r.errs  = m_tdata[81:62];
        r.qb    = m_tdata[95:82];
        r.qa    = m_tdata[109:96];
        r.mb    = m_tdata[136:110];
        r.ma    = m_tdata[163:137];
        r.last  = m_tlast;
        return r;
    endfunction

    // Send one sample, holding valid until accepted
    task automatic send(input logic lok, input logic [15:0] lh, input logic rok,
                        input logic [15:0] rh, input logic tend);
        while (idle_now())
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tdata  <= {6'd0, rh, rok, lh, lok};
        s_tlast  <= tend;
        s_tvalid <= 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_sample(lok, lh, rok, rh, tend);
        n_samples++;
    endtask

    task automatic write_mode(input logic v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {REG_PUPIL_MODE, 2'b00};
        pwdata <= {$urandom_range(1) ? 31'h7FFFFFFF : 31'h0, v};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        mode = v;
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending_q.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // Falling or flat heights with a mix of flags, random content
    task automatic random_trial(input int len, input bit falling);
        logic [15:0] lh, rh;
        lh = falling ? 16'd60000 : 16'($urandom);
        rh = falling ? 16'd60000 : 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (falling)
            begin
                lh = lh > 3000 ? 16'(lh - $urandom_range(2000, 1)) : 16'($urandom_range(1));
                rh = $urandom_range(3) == 0 ? 16'($urandom) : 16'(rh - $urandom_range(1000));
            end
            else if ($urandom_range(3) == 0)
            begin
                lh = 16'($urandom); rh = $urandom_range(3) == 0 ? 16'd0 : 16'($urandom);
            end
            send($urandom_range(99) >= 30, lh, $urandom_range(99) >= 30, rh, i == len - 1);
        end
    endtask

    // Receiver with random stall
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check(take_result());
        m_tready <= !idle_now();
    end

    initial
    begin
        #2_000_000;
        $display("eye_sample_gap_dilation_quality_core test failed");
        $finish;
    end

    initial
    begin
        mode = 0; fill = 0; count = 0; calm = 0; n_trials = 0; n_samples = 0;
        clear_eye(le); clear_eye(re);
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: single-sample trial, two-sample trial, extremes
        send(1, 16'hFFFF, 0, 16'h0, 1);
        send(0, 16'h0, 1, 16'hFFFF, 0);
        send(1, 16'h1, 1, 16'h1, 1);
        send(1, 16'd100, 1, 16'd100, 0);
        send(1, 16'd100, 1, 16'd100, 0);
        send(0, 16'd50, 1, 16'd100, 0);
        send(1, 16'd100, 1, 16'd100, 0);
        send(1, 16'd100, 0, 16'd0, 0);
        send(1, 16'd100, 1, 16'd100, 1);
        send(0, 16'h0, 0, 16'h0, 1);
        drain();

        // Pupil mode: falling, zero and flat heights
        write_mode(1);
        send(1, 16'd300, 1, 16'd300, 0);
        send(1, 16'd200, 1, 16'd300, 0);
        send(0, 16'd100, 0, 16'd300, 0);
        send(1, 16'd400, 1, 16'd300, 0);
        send(0, 16'd0, 1, 16'hFFFF, 0);
        send(1, 16'd400, 0, 16'd300, 0);
        send(1, 16'd400, 1, 16'd300, 1);
        send(0, 16'd5, 0, 16'd0, 0);
        send(0, 16'd5, 1, 16'd1, 1);
        drain();

        // Random trials across modes; hold back for a full drain between phases
        for (int p = 0; p < 8; p++)
        begin
            write_mode(p % 2);
            calm = (p == 2);
            for (int t = 0; t < 4; t++)
                random_trial($urandom_range(t == 0 ? 3 : 12, 1), p >= 3 && t % 2 == 0);
            drain();
        end
        calm = 0;

        $display("Covered %0d samples in %0d trials, %0d results checked in both modes.",
                 n_samples, n_trials, board.checked);
        if (errors == 0 && board.pending_q.size() == 0)
            $display("eye_sample_gap_dilation_quality_core test passed");
        else
            $display("eye_sample_gap_dilation_quality_core test failed");
        $finish;
    end
endmodule
